### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed: next-cycle implication");

`endif

### src/rufe_pkg.sv
// ----------------------------------------------------------------------------
// rufe_pkg
// Shared codes, widths and defaults of the buffered RS485 serial engine.
// ----------------------------------------------------------------------------
package rufe_pkg;

    // Default FIFO depths.
    localparam int RX_DEPTH_DEF = 64;
    localparam int TX_DEPTH_DEF = 64;

    // Fixed field widths.
    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int LEVEL_W = 7;
    localparam int CNT_W   = 16;
    localparam int IDX_W   = 2;
    localparam int CFG_W   = 7;

    // Event codes.
    localparam logic [CMD_W-1:0] CMD_HOST_WRITE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HOST_READ   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LINE_BYTE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TX_EMPTY    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TX_COMPLETE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LINE_IDLE   = 3'd5;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HOST = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LINE = 2'd2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_RX_WATERMARK    = 2'd0;
    localparam logic [IDX_W-1:0] REG_RECEIVE_ENABLE  = 2'd1;
    localparam logic [IDX_W-1:0] REG_TRANSMIT_ENABLE = 2'd2;

    // Register reset values.
    localparam logic [LEVEL_W-1:0] WATERMARK_RST = 7'd32;

    // Saturation limit of the drop counter.
    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

endpackage

### src/rs485_uart_fifo_engine_core.sv
// ----------------------------------------------------------------------------
// rs485_uart_fifo_engine_core
// Buffered half-duplex serial engine with receive and transmit ring FIFOs
// and RS485 driver/receiver turnaround.
// ----------------------------------------------------------------------------
// Each input word is one event. A host read that finds data and a
// transmitter-empty tick that sends a byte pass through S_READ, as the byte
// comes out of the registered RAM read port; other results are registered
// directly. A new word is taken when the engine is not waiting on a RAM read
// and the output register is empty or being emptied in the same cycle. The
// FIFO RAMs have no reset and need no clearing pass: an entry is only read
// after it has been written. Pointers and status reset at once.
module rs485_uart_fifo_engine_core
    import rufe_pkg::*;
#(
    parameter int RX_DEPTH = RX_DEPTH_DEF,
    parameter int TX_DEPTH = TX_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // Configuration port.
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    // Input channel.
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [BYTE_W-1:0]  data_in,
    // Output channel.
    output logic               out_valid,
    input  logic               out_ready,
    output logic [BYTE_W-1:0]  data_out,
    output logic [KIND_W-1:0]  out_kind,
    output logic               write_accepted,
    output logic               read_empty,
    output logic [LEVEL_W-1:0] rx_level,
    output logic [LEVEL_W-1:0] tx_level,
    output logic               rx_notify,
    output logic               tx_space_notify,
    output logic               driver_on,
    output logic               receiver_on,
    output logic [CNT_W-1:0]   overflow_count
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int RX_PW = $clog2(2 * RX_DEPTH);
    localparam int TX_PW = $clog2(2 * TX_DEPTH);
    localparam int RX_LW = $clog2(RX_DEPTH + 1);
    localparam int TX_LW = $clog2(TX_DEPTH + 1);

    localparam logic [RX_PW:0]    RX_WRAP = (RX_PW + 1)'(2 * RX_DEPTH);
    localparam logic [TX_PW:0]    TX_WRAP = (TX_PW + 1)'(2 * TX_DEPTH);
    localparam logic [RX_PW-1:0]  RX_PTR_LAST = RX_PW'(2 * RX_DEPTH - 1);
    localparam logic [TX_PW-1:0]  TX_PTR_LAST = TX_PW'(2 * TX_DEPTH - 1);
    localparam logic [RX_PW-1:0]  RX_PTR_D = RX_PW'(RX_DEPTH);
    localparam logic [TX_PW-1:0]  TX_PTR_D = TX_PW'(TX_DEPTH);
    localparam logic [RX_LW-1:0]  RX_FULL = RX_LW'(RX_DEPTH);
    localparam logic [TX_LW-1:0]  TX_FULL = TX_LW'(TX_DEPTH);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    // Fill level of a ring whose pointers run modulo twice the depth.
    function automatic logic [RX_LW-1:0] rx_lvl_f(input logic [RX_PW-1:0] wr,
                                                  input logic [RX_PW-1:0] rd);
        logic [RX_PW:0] diff;
        if (wr >= rd)
        begin
            diff = {1'b0, wr} - {1'b0, rd};
        end
        else
        begin
            diff = {1'b0, wr} + RX_WRAP - {1'b0, rd};
        end
        return RX_LW'(diff);
    endfunction

    function automatic logic [TX_LW-1:0] tx_lvl_f(input logic [TX_PW-1:0] wr,
                                                  input logic [TX_PW-1:0] rd);
        logic [TX_PW:0] diff;
        if (wr >= rd)
        begin
            diff = {1'b0, wr} - {1'b0, rd};
        end
        else
        begin
            diff = {1'b0, wr} + TX_WRAP - {1'b0, rd};
        end
        return TX_LW'(diff);
    endfunction

    // RAM slot of a pointer.
    function automatic logic [RX_AW-1:0] rx_slot_f(input logic [RX_PW-1:0] p);
        return (p >= RX_PTR_D) ? RX_AW'(p - RX_PTR_D) : RX_AW'(p);
    endfunction

    function automatic logic [TX_AW-1:0] tx_slot_f(input logic [TX_PW-1:0] p);
        return (p >= TX_PTR_D) ? TX_AW'(p - TX_PTR_D) : TX_AW'(p);
    endfunction

    // Pointer advance with wrap at twice the depth.
    function automatic logic [RX_PW-1:0] rx_inc_f(input logic [RX_PW-1:0] p);
        return (p == RX_PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [TX_PW-1:0] tx_inc_f(input logic [TX_PW-1:0] p);
        return (p == TX_PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // Configuration registers.
    logic [LEVEL_W-1:0] watermark_reg;
    logic               rx_en_reg;
    logic               tx_en_reg;

    // Engine state.
    state_t             state_reg, state_next;
    logic [RX_PW-1:0]   rx_wr_reg, rx_wr_next;
    logic [RX_PW-1:0]   rx_rd_reg, rx_rd_next;
    logic [TX_PW-1:0]   tx_wr_reg, tx_wr_next;
    logic [TX_PW-1:0]   tx_rd_reg, tx_rd_next;
    logic               tick_armed_reg, tick_armed_next;
    logic               cplt_armed_reg, cplt_armed_next;
    logic               driver_reg, driver_next;
    logic               receiver_reg, receiver_next;
    logic [CNT_W-1:0]   drop_reg, drop_next;
    logic               read_tx_reg, read_tx_next;

    // Output register.
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  data_out_reg;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic               wr_ok_reg, wr_ok_next;
    logic               rd_empty_reg, rd_empty_next;
    logic [LEVEL_W-1:0] rx_level_reg, tx_level_reg;
    logic               rx_note_reg, rx_note_next;
    logic               tx_note_reg, tx_note_next;

    // RAM ports.
    logic               rx_we, rx_re, tx_we, tx_re;
    logic [BYTE_W-1:0]  rx_rdata, tx_rdata;

    logic               accept;
    logic               need_read;
    logic [RX_LW-1:0]   rx_lvl;
    logic [TX_LW-1:0]   tx_lvl;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign rx_lvl   = rx_lvl_f(rx_wr_reg, rx_rd_reg);
    assign tx_lvl   = tx_lvl_f(tx_wr_reg, tx_rd_reg);

    // Event decode: pointer and flag updates, RAM accesses, result flags.
    always_comb
    begin
        rx_wr_next      = rx_wr_reg;
        rx_rd_next      = rx_rd_reg;
        tx_wr_next      = tx_wr_reg;
        tx_rd_next      = tx_rd_reg;
        tick_armed_next = tick_armed_reg;
        cplt_armed_next = cplt_armed_reg;
        driver_next     = driver_reg;
        receiver_next   = receiver_reg;
        drop_next       = drop_reg;
        read_tx_next    = read_tx_reg;
        kind_next       = KIND_NONE;
        wr_ok_next      = 1'b0;
        rd_empty_next   = 1'b0;
        rx_note_next    = 1'b0;
        tx_note_next    = 1'b0;
        rx_we           = 1'b0;
        rx_re           = 1'b0;
        tx_we           = 1'b0;
        tx_re           = 1'b0;
        need_read       = 1'b0;
        if (accept)
        begin
            case (cmd)
                CMD_HOST_WRITE:
                begin
                    if (tx_lvl < TX_FULL)
                    begin
                        tx_we      = 1'b1;
                        tx_wr_next = tx_inc_f(tx_wr_reg);
                        wr_ok_next = 1'b1;
                    end
                    tick_armed_next = 1'b1;
                end
                CMD_HOST_READ:
                begin
                    if (rx_lvl != '0)
                    begin
                        rx_re        = 1'b1;
                        rx_rd_next   = rx_inc_f(rx_rd_reg);
                        kind_next    = KIND_HOST;
                        need_read    = 1'b1;
                        read_tx_next = 1'b0;
                    end
                    else
                    begin
                        rd_empty_next = 1'b1;
                    end
                end
                CMD_LINE_BYTE:
                begin
                    if (rx_en_reg && receiver_reg)
                    begin
                        if (rx_lvl < RX_FULL)
                        begin
                            rx_we      = 1'b1;
                            rx_wr_next = rx_inc_f(rx_wr_reg);
                            drop_next  = '0;
                        end
                        else if (drop_reg != CNT_MAX)
                        begin
                            drop_next = drop_reg + 1'b1;
                        end
                        if (32'(rx_lvl) > 32'(watermark_reg))
                        begin
                            rx_note_next = 1'b1;
                        end
                    end
                end
                CMD_TX_EMPTY:
                begin
                    if (tx_en_reg && tick_armed_reg)
                    begin
                        if (tx_lvl == '0)
                        begin
                            tick_armed_next = 1'b0;
                            cplt_armed_next = 1'b1;
                            tx_note_next    = 1'b1;
                        end
                        else
                        begin
                            receiver_next = 1'b0;
                            driver_next   = 1'b1;
                            tx_re         = 1'b1;
                            tx_rd_next    = tx_inc_f(tx_rd_reg);
                            kind_next     = KIND_LINE;
                            need_read     = 1'b1;
                            read_tx_next  = 1'b1;
                        end
                    end
                end
                CMD_TX_COMPLETE:
                begin
                    if (cplt_armed_reg)
                    begin
                        driver_next     = 1'b0;
                        receiver_next   = 1'b1;
                        cplt_armed_next = 1'b0;
                    end
                end
                CMD_LINE_IDLE:
                begin
                    rx_note_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer: a RAM read holds the result back through the S_READ state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && need_read)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, configuration and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            watermark_reg  <= WATERMARK_RST;
            rx_en_reg      <= 1'b1;
            tx_en_reg      <= 1'b1;
            state_reg      <= S_IDLE;
            rx_wr_reg      <= '0;
            rx_rd_reg      <= '0;
            tx_wr_reg      <= '0;
            tx_rd_reg      <= '0;
            tick_armed_reg <= 1'b0;
            cplt_armed_reg <= 1'b0;
            driver_reg     <= 1'b0;
            receiver_reg   <= 1'b1;
            drop_reg       <= '0;
            read_tx_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            data_out_reg   <= '0;
            kind_reg       <= KIND_NONE;
            wr_ok_reg      <= 1'b0;
            rd_empty_reg   <= 1'b0;
            rx_level_reg   <= '0;
            tx_level_reg   <= '0;
            rx_note_reg    <= 1'b0;
            tx_note_reg    <= 1'b0;
        end
        else
        begin
            // Register writes; unknown indexes are ignored.
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RX_WATERMARK:    watermark_reg <= cfg_data;
                    REG_RECEIVE_ENABLE:  rx_en_reg     <= cfg_data[0];
                    REG_TRANSMIT_ENABLE: tx_en_reg     <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            state_reg      <= state_next;
            rx_wr_reg      <= rx_wr_next;
            rx_rd_reg      <= rx_rd_next;
            tx_wr_reg      <= tx_wr_next;
            tx_rd_reg      <= tx_rd_next;
            tick_armed_reg <= tick_armed_next;
            cplt_armed_reg <= cplt_armed_next;
            driver_reg     <= driver_next;
            receiver_reg   <= receiver_next;
            drop_reg       <= drop_next;
            read_tx_reg    <= read_tx_next;

            // The output register empties when the word is taken.
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Capture the result; the byte follows the RAM read if there is one.
            if (accept)
            begin
                kind_reg     <= kind_next;
                wr_ok_reg    <= wr_ok_next;
                rd_empty_reg <= rd_empty_next;
                rx_level_reg <= LEVEL_W'(rx_lvl_f(rx_wr_next, rx_rd_next));
                tx_level_reg <= LEVEL_W'(tx_lvl_f(tx_wr_next, tx_rd_next));
                rx_note_reg  <= rx_note_next;
                tx_note_reg  <= tx_note_next;
                data_out_reg <= '0;
                if (!need_read)
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            if (state_reg == S_READ)
            begin
                data_out_reg  <= read_tx_reg ? tx_rdata : rx_rdata;
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Receive FIFO storage. Reads and writes come from different words,
    // so a read never meets a write to the same entry in flight.
    rufe_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_slot_f(rx_wr_reg)),
        .wdata (data_in),
        .re    (rx_re),
        .raddr (rx_slot_f(rx_rd_reg)),
        .rdata (rx_rdata)
    );

    // Transmit FIFO storage.
    rufe_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_slot_f(tx_wr_reg)),
        .wdata (data_in),
        .re    (tx_re),
        .raddr (tx_slot_f(tx_rd_reg)),
        .rdata (tx_rdata)
    );

    assign out_valid       = out_valid_reg;
    assign data_out        = data_out_reg;
    assign out_kind        = kind_reg;
    assign write_accepted  = wr_ok_reg;
    assign read_empty      = rd_empty_reg;
    assign rx_level        = rx_level_reg;
    assign tx_level        = tx_level_reg;
    assign rx_notify       = rx_note_reg;
    assign tx_space_notify = tx_note_reg;
    assign driver_on       = driver_reg;
    assign receiver_on     = receiver_reg;
    assign overflow_count  = drop_reg;

endmodule

### src/rufe_ram.sv
// ----------------------------------------------------------------------------
// rufe_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rufe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/rufe_checker.sv
// ----------------------------------------------------------------------------
// rufe_checker
// Port-level checks of the buffered RS485 serial engine, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rufe_checker
    import rufe_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [BYTE_W-1:0]  data_out,
    input logic [KIND_W-1:0]  out_kind,
    input logic               write_accepted,
    input logic               read_empty,
    input logic [LEVEL_W-1:0] rx_level,
    input logic               driver_on,
    input logic               receiver_on
);

    // A stalled output word holds its byte.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(data_out))

    // Driver and receiver are in opposite directions whenever a word is valid.
    `ASSERT_SAME(a_direction, clk, rst_n, out_valid, driver_on != receiver_on)

    // A byte to the line is only reported with the driver on.
    `ASSERT_SAME(a_line_driver, clk, rst_n, out_valid && (out_kind == KIND_LINE), driver_on)

    // An empty host read reports an empty receive FIFO and no byte.
    `ASSERT_SAME(a_read_empty, clk, rst_n, out_valid && read_empty, (rx_level == '0) && (out_kind == KIND_NONE) && (data_out == '0))

    // A stored host write carries no byte and no empty flag.
    `ASSERT_SAME(a_write_ok, clk, rst_n, out_valid && write_accepted, (out_kind == KIND_NONE) && !read_empty)

endmodule

bind rs485_uart_fifo_engine_core rufe_checker u_rufe_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data_out       (data_out),
    .out_kind       (out_kind),
    .write_accepted (write_accepted),
    .read_empty     (read_empty),
    .rx_level       (rx_level),
    .driver_on      (driver_on),
    .receiver_on    (receiver_on)
);

### dv/tb_rs485_uart_fifo_engine_core.sv
// ----------------------------------------------------------------------------
// tb_rs485_uart_fifo_engine_core
// Self-checking testbench for the buffered RS485 serial engine. A behavioral
// model of both FIFOs, the tick and completion arming and the direction
// control predicts the status word of every accepted event. A checker
// compares each output word field by field in order. Directed tests cover
// the corner events and the configuration registers. FIFO limit and drop
// counter tests follow. Random traffic runs under three handshake idling
// profiles.
// ----------------------------------------------------------------------------
module tb_rs485_uart_fifo_engine_core;
    import rufe_pkg::*;

    // Reserved event codes and the unused register index.
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int RX_DEPTH    = RX_DEPTH_DEF;
    localparam int TX_DEPTH    = TX_DEPTH_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int PRINT_LIMIT = 100;

    // One expected output word.
    typedef struct packed {
        logic [BYTE_W-1:0]  data_out;
        logic [KIND_W-1:0]  out_kind;
        logic               write_accepted;
        logic               read_empty;
        logic [LEVEL_W-1:0] rx_level;
        logic [LEVEL_W-1:0] tx_level;
        logic               rx_notify;
        logic               tx_space_notify;
        logic               driver_on;
        logic               receiver_on;
        logic [CNT_W-1:0]   overflow_count;
    } engine_status_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [CMD_W-1:0]   cmd = '0;
    logic [BYTE_W-1:0]  data_in = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [BYTE_W-1:0]  data_out;
    logic [KIND_W-1:0]  out_kind;
    logic               write_accepted;
    logic               read_empty;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
    logic               rx_notify;
    logic               tx_space_notify;
    logic               driver_on;
    logic               receiver_on;
    logic [CNT_W-1:0]   overflow_count;

    // Model state, starting from the reset values.
    logic [BYTE_W-1:0]  rx_mem [RX_DEPTH];
    logic [BYTE_W-1:0]  tx_mem [TX_DEPTH];
    logic [LEVEL_W-1:0] rx_wptr = '0;
    logic [LEVEL_W-1:0] rx_rptr = '0;
    logic [LEVEL_W-1:0] tx_wptr = '0;
    logic [LEVEL_W-1:0] tx_rptr = '0;
    logic               tick_armed = 1'b0;
    logic               done_armed = 1'b0;
    logic               drv_state = 1'b0;
    logic               rcv_state = 1'b1;
    logic [CNT_W-1:0]   drop_cnt = '0;

    // Model copy of the configuration registers.
    logic [LEVEL_W-1:0] wm_reg = WATERMARK_RST;
    logic               rx_en_reg = 1'b1;
    logic               tx_en_reg = 1'b1;

    engine_status_t     expected_status_q [$];
    int unsigned        words_sent = 0;
    int unsigned        mismatch_count = 0;
    int unsigned        stall_cycles = 0;
    int unsigned        send_idle_pct = 0;
    int unsigned        recv_idle_pct = 0;

    rs485_uart_fifo_engine_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .data_in         (data_in),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .data_out        (data_out),
        .out_kind        (out_kind),
        .write_accepted  (write_accepted),
        .read_empty      (read_empty),
        .rx_level        (rx_level),
        .tx_level        (tx_level),
        .rx_notify       (rx_notify),
        .tx_space_notify (tx_space_notify),
        .driver_on       (driver_on),
        .receiver_on     (receiver_on),
        .overflow_count  (overflow_count)
    );

    // Clock generator.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one event to the engine model and return the status it produces.
    function automatic engine_status_t engine_step(input logic [CMD_W-1:0] c,
                                                   input logic [BYTE_W-1:0] d);
        engine_status_t     r;
        logic [LEVEL_W-1:0] lvl;
        r = '0;
        case (c)
            CMD_HOST_WRITE:
            begin
                lvl = tx_wptr - tx_rptr;
                if (lvl < TX_DEPTH)
                begin
                    tx_mem[tx_wptr[LEVEL_W-2:0]] = d;
                    tx_wptr = tx_wptr + 1'b1;
                    r.write_accepted = 1'b1;
                end
                tick_armed = 1'b1;
            end
            CMD_HOST_READ:
            begin
                lvl = rx_wptr - rx_rptr;
                if (lvl > 0)
                begin
                    r.data_out = rx_mem[rx_rptr[LEVEL_W-2:0]];
                    r.out_kind = KIND_HOST;
                    rx_rptr = rx_rptr + 1'b1;
                end
                else
                begin
                    r.read_empty = 1'b1;
                end
            end
            CMD_LINE_BYTE:
            begin
                if (rx_en_reg && rcv_state)
                begin
                    lvl = rx_wptr - rx_rptr;
                    if (lvl < RX_DEPTH)
                    begin
                        rx_mem[rx_wptr[LEVEL_W-2:0]] = d;
                        rx_wptr = rx_wptr + 1'b1;
                        drop_cnt = '0;
                    end
                    else if (drop_cnt != CNT_MAX)
                    begin
                        drop_cnt = drop_cnt + 1'b1;
                    end
                    if (lvl > wm_reg)
                        r.rx_notify = 1'b1;
                end
            end
            CMD_TX_EMPTY:
            begin
                if (tx_en_reg && tick_armed)
                begin
                    lvl = tx_wptr - tx_rptr;
                    if (lvl == 0)
                    begin
                        tick_armed = 1'b0;
                        done_armed = 1'b1;
                        r.tx_space_notify = 1'b1;
                    end
                    else
                    begin
                        rcv_state = 1'b0;
                        drv_state = 1'b1;
                        r.data_out = tx_mem[tx_rptr[LEVEL_W-2:0]];
                        r.out_kind = KIND_LINE;
                        tx_rptr = tx_rptr + 1'b1;
                    end
                end
            end
            CMD_TX_COMPLETE:
            begin
                if (done_armed)
                begin
                    drv_state = 1'b0;
                    rcv_state = 1'b1;
                    done_armed = 1'b0;
                end
            end
            CMD_LINE_IDLE:
            begin
                r.rx_notify = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.rx_level = rx_wptr - rx_rptr;
        r.tx_level = tx_wptr - tx_rptr;
        r.driver_on = drv_state;
        r.receiver_on = rcv_state;
        r.overflow_count = drop_cnt;
        return r;
    endfunction

    // Print one mismatch line, up to a limit, and count it.
    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [CNT_W-1:0] got,
                                 input logic [CNT_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // Result checker and receiver-side stall generator.
    always @(posedge clk)
    begin
        engine_status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_status_q.size() == 0)
            begin
                report_mismatch("output word with no expected status pending");
            end
            else
            begin
                want = expected_status_q.pop_front();
                compare_field("data_out", data_out, want.data_out);
                compare_field("out_kind", out_kind, want.out_kind);
                compare_field("write_accepted", write_accepted, want.write_accepted);
                compare_field("read_empty", read_empty, want.read_empty);
                compare_field("rx_level", rx_level, want.rx_level);
                compare_field("tx_level", tx_level, want.tx_level);
                compare_field("rx_notify", rx_notify, want.rx_notify);
                compare_field("tx_space_notify", tx_space_notify, want.tx_space_notify);
                compare_field("driver_on", driver_on, want.driver_on);
                compare_field("receiver_on", receiver_on, want.receiver_on);
                compare_field("overflow_count", overflow_count, want.overflow_count);
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Send one event word and record its expected status on acceptance.
    task automatic send_word(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        data_in <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_status_q.push_back(engine_step(c, d));
        words_sent++;
    endtask

    // Hold the sender off until every expected word has arrived.
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one configuration register; call only while the engine is idle.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_RX_WATERMARK:    wm_reg = val;
            REG_RECEIVE_ENABLE:  rx_en_reg = val[0];
            REG_TRANSMIT_ENABLE: tx_en_reg = val[0];
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    // Tick out the whole transmit FIFO, then signal completion.
    task automatic finish_transmit();
        int unsigned        n;
        logic [LEVEL_W-1:0] lvl;
        lvl = tx_wptr - tx_rptr;
        n = lvl + 1;
        repeat (n)
        begin
            if ($urandom_range(5) == 0)
                send_word(CMD_LINE_BYTE, $urandom_range(255));
            send_word(CMD_TX_EMPTY, $urandom_range(255));
        end
        send_word(CMD_TX_COMPLETE, $urandom_range(255));
    endtask

    // Pick a new register setting, extremes included.
    task automatic randomize_config();
        logic [CFG_W-1:0] wm;
        case ($urandom_range(3))
            0:       wm = 7'd0;
            1:       wm = 7'd64;
            default: wm = $urandom_range(64);
        endcase
        wait_results_drained();
        write_reg(REG_RX_WATERMARK, wm);
        write_reg(REG_RECEIVE_ENABLE, ($urandom_range(9) != 0));
        write_reg(REG_TRANSMIT_ENABLE, ($urandom_range(9) != 0));
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, $urandom_range(127));
    endtask

    // Corner events from reset: empty read, unarmed tick and completion,
    // a full transmit turnaround and the reserved codes.
    task automatic test_event_basics();
        send_word(CMD_HOST_READ, 8'h00);
        send_word(CMD_TX_COMPLETE, 8'hFF);
        send_word(CMD_TX_EMPTY, 8'h00);
        send_word(CMD_LINE_BYTE, 8'h00);
        send_word(CMD_LINE_BYTE, 8'hFF);
        send_word(CMD_LINE_IDLE, 8'h3C);
        send_word(CMD_HOST_READ, 8'hC3);
        send_word(CMD_HOST_READ, 8'h00);
        send_word(CMD_HOST_WRITE, 8'hA5);
        send_word(CMD_HOST_WRITE, 8'h5A);
        send_word(CMD_TX_EMPTY, 8'h00);
        // The receiver is off while the driver is on.
        send_word(CMD_LINE_BYTE, 8'h77);
        send_word(CMD_TX_EMPTY, 8'h00);
        send_word(CMD_TX_EMPTY, 8'h00);
        send_word(CMD_TX_EMPTY, 8'h00);
        send_word(CMD_TX_COMPLETE, 8'h00);
        send_word(CMD_RSVD_6, 8'h81);
        send_word(CMD_RSVD_7, 8'h7E);
    endtask

    // Each register, plus a write to the unused index.
    task automatic test_config_registers();
        wait_results_drained();
        write_reg(REG_RX_WATERMARK, 7'd0);
        send_word(CMD_LINE_BYTE, 8'h11);
        send_word(CMD_LINE_BYTE, 8'h22);
        wait_results_drained();
        write_reg(REG_RECEIVE_ENABLE, 7'd0);
        send_word(CMD_LINE_BYTE, 8'h33);
        wait_results_drained();
        write_reg(REG_RECEIVE_ENABLE, 7'd1);
        write_reg(REG_TRANSMIT_ENABLE, 7'd0);
        send_word(CMD_HOST_WRITE, 8'hC3);
        send_word(CMD_TX_EMPTY, 8'h00);
        wait_results_drained();
        write_reg(REG_TRANSMIT_ENABLE, 7'd1);
        finish_transmit();
        wait_results_drained();
        write_reg(REG_UNUSED, 7'h7F);
        send_word(CMD_LINE_IDLE, 8'h00);
        wait_results_drained();
        write_reg(REG_RX_WATERMARK, 7'd64);
    endtask

    // Fill both FIFOs past full and empty them again.
    task automatic test_fifo_limits();
        int unsigned        n;
        logic [LEVEL_W-1:0] lvl;
        wait_results_drained();
        write_reg(REG_RX_WATERMARK, 7'd63);
        lvl = rx_wptr - rx_rptr;
        n = lvl + 1;
        repeat (n) send_word(CMD_HOST_READ, 8'h00);
        repeat (RX_DEPTH + 2) send_word(CMD_LINE_BYTE, $urandom_range(255));
        repeat (RX_DEPTH + 2) send_word(CMD_HOST_READ, $urandom_range(255));
        repeat (TX_DEPTH + 1) send_word(CMD_HOST_WRITE, $urandom_range(255));
        finish_transmit();
        wait_results_drained();
        write_reg(REG_RX_WATERMARK, WATERMARK_RST);
    endtask

    // Keep the receive FIFO full while line bytes are dropped and counted.
    task automatic test_drop_saturation();
        int unsigned        n;
        logic [LEVEL_W-1:0] lvl;
        wait_results_drained();
        write_reg(REG_RECEIVE_ENABLE, 7'd1);
        write_reg(REG_TRANSMIT_ENABLE, 7'd1);
        finish_transmit();
        lvl = rx_wptr - rx_rptr;
        n = RX_DEPTH - lvl;
        repeat (n + 40) send_word(CMD_LINE_BYTE, $urandom_range(255));
        // A stored byte clears the count again.
        send_word(CMD_HOST_READ, 8'h00);
        send_word(CMD_LINE_BYTE, $urandom_range(255));
    endtask

    // Random traffic made mostly of bursts and transmit sessions.
    task automatic test_random_traffic(input int unsigned n_words);
        int unsigned stop_at;
        int unsigned next_cfg;
        int unsigned n;
        stop_at = words_sent + n_words;
        next_cfg = words_sent + $urandom_range(100, 250);
        while (words_sent < stop_at)
        begin
            if (words_sent >= next_cfg)
            begin
                randomize_config();
                next_cfg = words_sent + $urandom_range(100, 250);
            end
            case ($urandom_range(9))
                0, 1, 2:
                begin
                    n = $urandom_range(1, 80);
                    repeat (n)
                    begin
                        if ($urandom_range(7) == 0)
                            send_word(CMD_HOST_READ, $urandom_range(255));
                        else
                            send_word(CMD_LINE_BYTE, $urandom_range(255));
                    end
                end
                3, 4:
                begin
                    n = $urandom_range(1, 70);
                    repeat (n) send_word(CMD_HOST_READ, $urandom_range(255));
                end
                5, 6:
                begin
                    n = $urandom_range(1, 70);
                    repeat (n) send_word(CMD_HOST_WRITE, $urandom_range(255));
                    finish_transmit();
                end
                7:
                begin
                    send_word(CMD_LINE_IDLE, $urandom_range(255));
                    if ($urandom_range(3) == 0)
                        wait_results_drained();
                end
                default:
                begin
                    n = $urandom_range(1, 10);
                    repeat (n) send_word($urandom_range(7), $urandom_range(255));
                end
            endcase
        end
    endtask

    // Test sequence.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles rarely, receiver stalls often.
        send_idle_pct = 13;
        recv_idle_pct = 67;
        test_event_basics();
        test_config_registers();
        test_fifo_limits();
        test_random_traffic(450);

        // Sender idles often, receiver stalls rarely.
        wait_results_drained();
        send_idle_pct = 67;
        recv_idle_pct = 13;
        randomize_config();
        test_random_traffic(450);

        // No idling on either side.
        wait_results_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_drop_saturation();
        randomize_config();
        test_random_traffic(450);

        wait_results_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
